[rtl/lmss_pkg.sv]
// package for the led matrix shift scanner
// item and result types, mode and register codes, sizing constants; no dependencies
package lmss_pkg;

    localparam int ROWS       = 8;
    localparam int HOLD_WIDTH = 16;

    localparam int ROW_W  = (ROWS > 8) ? 4 : 3;
    localparam int CMP_W  = (HOLD_WIDTH > 16) ? HOLD_WIDTH : 16;
    localparam int SLOT_W = 3;
    localparam int TABLE_DEPTH = 8;

    localparam logic [1:0] MODE_TICK   = 2'd0;
    localparam logic [1:0] MODE_COLUMN = 2'd1;
    localparam logic [1:0] MODE_ROW    = 2'd2;

    localparam logic [1:0] REG_ON_TICKS     = 2'd0;
    localparam logic [1:0] REG_PERIOD_TICKS = 2'd1;

    localparam logic [15:0] ON_TICKS_RESET     = 16'd50;
    localparam logic [15:0] PERIOD_TICKS_RESET = 16'd300;
    localparam logic [7:0]  COLUMN_RESET       = 8'h00;
    localparam logic [7:0]  ROW_RESET          = 8'hFF;
    localparam logic [15:0] BLANK_WORD         = {COLUMN_RESET, ROW_RESET};

    typedef struct packed {
        logic [1:0] mode;
        logic [2:0] row_slot;
        logic [7:0] byte_value;
    } item_t;

    typedef struct packed {
        logic       serial_data;
        logic       shift_clock;
        logic       latch_clock;
        logic [2:0] current_row;
    } result_t;

    typedef struct packed {
        logic              column_we;
        logic              row_we;
        logic [SLOT_W-1:0] slot;
        logic [7:0]        data;
    } tbl_wr_t;

    typedef struct packed {
        logic serial_data;
        logic shift_clock;
        logic latch_clock;
    } pins_t;

endpackage

[rtl/lmss_tables.sv]
// column pattern and row select tables, 8 entries each, flop based
// depends on lmss_pkg
module lmss_tables
    import lmss_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  tbl_wr_t           wr,
    input  logic [SLOT_W-1:0] rd_index,
    output logic [7:0]        rd_column,
    output logic [7:0]        rd_row
);

    logic [7:0] column_reg [TABLE_DEPTH];
    logic [7:0] row_reg    [TABLE_DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                column_reg[i] <= COLUMN_RESET;
                row_reg[i]    <= ROW_RESET;
            end
        end
        else
        begin
            if (wr.column_we)
                column_reg[wr.slot] <= wr.data;
            if (wr.row_we)
                row_reg[wr.slot] <= wr.data;
        end
    end

    assign rd_column = column_reg[rd_index];
    assign rd_row    = row_reg[rd_index];

endmodule

[rtl/lmss_sequencer.sv]
// pin sequencer: shift, latch and hold phases for lit and blanking words
// depends on lmss_pkg
module lmss_sequencer
    import lmss_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             tick,
    input  logic [15:0]      on_ticks,
    input  logic [15:0]      period_ticks,
    input  logic [7:0]       column_byte,
    input  logic [7:0]       row_byte,
    output logic [ROW_W-1:0] row_now,
    output pins_t            pins_next,
    output logic [ROW_W-1:0] row_next
);

    localparam logic [2:0] PH_SHIFT_LIT   = 3'd0;
    localparam logic [2:0] PH_LATCH_LIT   = 3'd1;
    localparam logic [2:0] PH_HOLD_ON     = 3'd2;
    localparam logic [2:0] PH_SHIFT_BLANK = 3'd3;
    localparam logic [2:0] PH_LATCH_BLANK = 3'd4;
    localparam logic [2:0] PH_HOLD_OFF    = 3'd5;

    logic [2:0]            phase_reg, phase_next;
    logic [ROW_W-1:0]      row_reg;
    logic [3:0]            bit_reg, bit_next;
    logic                  half_reg, half_next;
    logic [HOLD_WIDTH-1:0] hold_reg, hold_next;
    pins_t                 pins_reg;

    logic [15:0]           off_target;
    logic [15:0]           word;
    logic                  lit;
    logic [15:0]           target;
    logic [HOLD_WIDTH-1:0] hold_inc;
    logic [ROW_W-1:0]      row_adv;

    assign off_target = (period_ticks > on_ticks) ? (period_ticks - on_ticks) : 16'd0;
    assign row_adv    = (row_reg == ROW_W'(ROWS - 1)) ? '0 : row_reg + 1'b1;
    assign hold_inc   = hold_reg + 1'b1;

    always_comb
    begin
        phase_next = phase_reg;
        row_next   = row_reg;
        bit_next   = bit_reg;
        half_next  = half_reg;
        hold_next  = hold_reg;
        pins_next  = pins_reg;
        lit        = 1'b1;
        word       = {column_byte, row_byte};
        target     = on_ticks;
        if (tick)
        begin
            case (phase_reg)
                PH_LATCH_LIT, PH_LATCH_BLANK:
                begin
                    lit    = (phase_reg == PH_LATCH_LIT);
                    target = lit ? on_ticks : off_target;
                    pins_next.shift_clock = 1'b0;
                    pins_next.latch_clock = 1'b1;
                    hold_next = '0;
                    if (target == 16'd0)
                    begin
                        if (lit)
                            phase_next = PH_SHIFT_BLANK;
                        else
                        begin
                            row_next   = row_adv;
                            phase_next = PH_SHIFT_LIT;
                        end
                    end
                    else
                        phase_next = lit ? PH_HOLD_ON : PH_HOLD_OFF;
                end
                PH_HOLD_ON, PH_HOLD_OFF:
                begin
                    lit    = (phase_reg == PH_HOLD_ON);
                    target = lit ? on_ticks : off_target;
                    if (CMP_W'(hold_inc) >= CMP_W'(target))
                    begin
                        hold_next = '0;
                        if (lit)
                            phase_next = PH_SHIFT_BLANK;
                        else
                        begin
                            row_next   = row_adv;
                            phase_next = PH_SHIFT_LIT;
                        end
                    end
                    else
                        hold_next = hold_inc;
                end
                default:
                begin
                    // shift lit, shift blank, and unused codes as a lit shift start
                    lit  = (phase_reg != PH_SHIFT_BLANK);
                    word = lit ? {column_byte, row_byte} : BLANK_WORD;
                    phase_next = lit ? PH_SHIFT_LIT : PH_SHIFT_BLANK;
                    pins_next.serial_data = word[4'd15 - bit_reg];
                    pins_next.shift_clock = half_reg;
                    pins_next.latch_clock = 1'b0;
                    if (!half_reg)
                        half_next = 1'b1;
                    else
                    begin
                        half_next = 1'b0;
                        bit_next  = bit_reg + 1'b1;
                        if (bit_reg == 4'd15)
                            phase_next = lit ? PH_LATCH_LIT : PH_LATCH_BLANK;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SHIFT_LIT;
            row_reg   <= '0;
            bit_reg   <= '0;
            half_reg  <= 1'b0;
            hold_reg  <= '0;
            pins_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            row_reg   <= row_next;
            bit_reg   <= bit_next;
            half_reg  <= half_next;
            hold_reg  <= hold_next;
            pins_reg  <= pins_next;
        end
    end

    assign row_now = row_reg;

endmodule

[rtl/led_matrix_shift_scanner_core.sv]
// top level of the led matrix shift scanner: input register, tables, sequencer, result register
// depends on lmss_pkg, lmss_tables, lmss_sequencer
//
// usage
//   item channel: item_valid / item_ready / item. mode tick advances the pin
//   sequence by one step; mode column or row stores byte_value in the table
//   entry row_slot. every item gives exactly one result.
//   result channel: result_valid / result_ready / result with the pin levels
//   and the row being scanned after the item.
//   config: cfg_write with cfg_index (0 on_ticks, 1 period_ticks) and cfg_data,
//   taken at once; other indexes are ignored. write only while idle.
//   path: an accepted item sits in the input register until the result
//   register is free or being taken, then its result is registered there.
//   throughput: one item per cycle while results are taken, set by the single
//   pass from the input register through table read and sequencer step into
//   the result register. stall: while result_ready is low the result holds;
//   one more item may sit in the input register, then item_ready drops.
//   reset: tables go to column 0x00 and row 0xFF, the sequence restarts at
//   the lit shift of row 0 with all pins low, registers at 50 and 300.
module led_matrix_shift_scanner_core
    import lmss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  item_t       item,
    output logic        result_valid,
    input  logic        result_ready,
    output result_t     result,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic        in_valid_reg;
    item_t       in_item_reg;
    logic        out_valid_reg;
    result_t     out_item_reg;
    logic [15:0] on_ticks_reg;
    logic [15:0] period_ticks_reg;

    logic             advance;
    logic             tick;
    tbl_wr_t          tbl_wr;
    logic [7:0]       rd_column;
    logic [7:0]       rd_row;
    logic [ROW_W-1:0] row_now;
    logic [ROW_W-1:0] row_next;
    pins_t            pins_next;

    assign advance    = in_valid_reg && (!out_valid_reg || result_ready);
    assign item_ready = !in_valid_reg || advance;
    assign tick       = advance && (in_item_reg.mode == MODE_TICK);

    assign tbl_wr.column_we = advance && (in_item_reg.mode == MODE_COLUMN);
    assign tbl_wr.row_we    = advance && (in_item_reg.mode == MODE_ROW);
    assign tbl_wr.slot      = in_item_reg.row_slot;
    assign tbl_wr.data      = in_item_reg.byte_value;

    lmss_tables u_tables (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (tbl_wr),
        .rd_index  (row_now[SLOT_W-1:0]),
        .rd_column (rd_column),
        .rd_row    (rd_row)
    );

    lmss_sequencer u_sequencer (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick         (tick),
        .on_ticks     (on_ticks_reg),
        .period_ticks (period_ticks_reg),
        .column_byte  (rd_column),
        .row_byte     (rd_row),
        .row_now      (row_now),
        .pins_next    (pins_next),
        .row_next     (row_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_ticks_reg     <= ON_TICKS_RESET;
            period_ticks_reg <= PERIOD_TICKS_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_ON_TICKS)
                on_ticks_reg <= cfg_data;
            else if (cfg_index == REG_PERIOD_TICKS)
                period_ticks_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_ready)
                in_valid_reg <= item_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
            in_item_reg <= item;
        if (advance)
        begin
            out_item_reg.serial_data <= pins_next.serial_data;
            out_item_reg.shift_clock <= pins_next.shift_clock;
            out_item_reg.latch_clock <= pins_next.latch_clock;
            out_item_reg.current_row <= row_next[SLOT_W-1:0];
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

endmodule

[rtl/lmss_checker.sv]
// port level checks for the led matrix shift scanner, bound to the top level
// depends on lmss_pkg and led_matrix_shift_scanner_core
module lmss_checker
    import lmss_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        item_valid,
    input logic        item_ready,
    input logic        result_valid,
    input logic        result_ready,
    input result_t     result
);

    // a stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // latch and shift clock are never high together
    a_pin_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.latch_clock && result.shift_clock))
        else $error("latch and shift clock both high");

    // a draining output never blocks the input side
    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        result_ready |-> item_ready)
        else $error("item_ready low while result is taken");

    // an item accepted into an empty pipe with a receiver that stays ready gives a valid result
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && !result_valid && result_ready ##1 result_ready
        |=> result_valid)
        else $error("result missing after item");

endmodule

bind led_matrix_shift_scanner_core lmss_checker u_lmss_checker (.*);
